>>> sv/sgvd_pkg.sv
package sgvd_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;
  localparam int IDX_W    = $clog2(CELLS);
  localparam int VEL_W    = 32;
  localparam int DIM_W    = 7;
  localparam int COEF_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [2:0] OP_WR_U  = 3'd0;
  localparam logic [2:0] OP_WR_V  = 3'd1;
  localparam logic [2:0] OP_WR_S  = 3'd2;
  localparam logic [2:0] OP_SWEEP = 3'd3;
  localparam logic [2:0] OP_RD_U  = 3'd4;
  localparam logic [2:0] OP_RD_V  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd3;

  // Linear cell index of a one-based (column, row) pair, column major.
  function automatic logic [IDX_W-1:0] cell_idx(logic [DIM_W-1:0] c, logic [DIM_W-1:0] r);
    int lin;
    lin = (int'(c) - 1) * MAX_ROWS + (int'(r) - 1);
    return lin[IDX_W-1:0];
  endfunction

endpackage

>>> sv/sgvd_ram.sv
module sgvd_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/staggered_grid_viscous_diffusion.sv
// Load items (write u, v or solid) may follow back to back. A read item passes its cell
// through the memory read register into the output register; the next item is accepted
// once that read is no longer pending and the output is not stalled. A sweep visits each
// face in turn, its steps set by the single read port of the memories (seven reads,
// multiply, write back). After reset a pass clears the solid mask, one cell per cycle,
// during which no item is accepted; configuration writes are taken throughout.
module staggered_grid_viscous_diffusion (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sgvd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sgvd_pkg::COEF_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [2:0]                         opcode_i,
  input  logic [sgvd_pkg::DIM_W-1:0]         col_i,
  input  logic [sgvd_pkg::DIM_W-1:0]         row_i,
  input  logic signed [sgvd_pkg::VEL_W-1:0]  velocity_in_i,
  input  logic                               solid_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [sgvd_pkg::VEL_W-1:0]  velocity_out_o,
  output logic                               sweep_done_o
);

  localparam int IW = sgvd_pkg::IDX_W;
  localparam int VW = sgvd_pkg::VEL_W;
  localparam int DW = sgvd_pkg::DIM_W;
  localparam int SW = VW + 3;             // width of l + r - 2c
  localparam int PW = SW + sgvd_pkg::COEF_W + 1;
  localparam logic [DW-1:0] MaxC = DW'(sgvd_pkg::MAX_COLS);
  localparam logic [DW-1:0] MaxR = DW'(sgvd_pkg::MAX_ROWS);
  localparam logic [DW-1:0] One  = DW'(1);
  localparam logic [DW-1:0] Two  = DW'(2);
  localparam logic [DW-1:0] MinusOne = {DW{1'b1}};
  localparam logic [IW-1:0] LastIdx  = IW'(sgvd_pkg::CELLS - 1);

  // Configuration registers.
  logic [sgvd_pkg::COEF_W-1:0] coeff_x_q, coeff_y_q;
  logic [DW-1:0]               cols_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_x_q <= '0;
      coeff_y_q <= '0;
      cols_q    <= MaxC;
      rows_q    <= MaxR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sgvd_pkg::CFG_COEFF_X: coeff_x_q <= cfg_data_i;
        sgvd_pkg::CFG_COEFF_Y: coeff_y_q <= cfg_data_i;
        sgvd_pkg::CFG_COLS:    cols_q    <= cfg_data_i[DW-1:0];
        sgvd_pkg::CFG_ROWS:    rows_q    <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  // Grid size clamped to the supported range when a sweep runs.
  logic [DW-1:0] nx, ny;
  assign nx = (cols_q < Two) ? Two : ((cols_q > MaxC) ? MaxC : cols_q);
  assign ny = (rows_q < Two) ? Two : ((rows_q > MaxR) ? MaxR : rows_q);

  // Control state.
  logic          clr_busy_q;
  logic [IW-1:0] clr_idx_q;
  logic          sweep_q;
  logic          phase_q;      // 0 relaxes horizontal faces, 1 vertical faces
  logic [DW-1:0] scol_q, srow_q;
  logic [3:0]    step_q;
  logic          rd_pend_q, rd_ok_q, rd_v_q;
  logic          out_valid_q, done_q;
  logic signed [VW-1:0] out_vel_q;

  logic accept;
  assign in_stall_o = clr_busy_q | sweep_q | rd_pend_q | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;

  logic in_ok;
  assign in_ok = (col_i >= One) && (col_i <= MaxC) && (row_i >= One) && (row_i <= MaxR);

  // Sweep address: each face reads seven cells, offset along the face normal (along) and
  // across it. For horizontal faces "along" is the column, for vertical faces the row.
  logic [DW-1:0] d_along, d_across, acol, arow;
  always_comb begin
    d_along  = '0;
    d_across = '0;
    case (step_q)
      4'd1: d_along = One;
      4'd2: d_across = MinusOne;
      4'd3: begin
        d_along  = One;
        d_across = MinusOne;
      end
      4'd4: d_across = One;
      4'd5: begin
        d_along  = One;
        d_across = One;
      end
      4'd6: d_along = MinusOne;
      default: ;
    endcase
    acol = scol_q + (phase_q ? d_across : d_along);
    arow = srow_q + (phase_q ? d_along : d_across);
  end

  logic [IW-1:0] rd_addr, sweep_addr, in_addr;
  assign sweep_addr = sgvd_pkg::cell_idx(acol, arow);
  assign in_addr    = sgvd_pkg::cell_idx(col_i, row_i);
  assign rd_addr    = sweep_q ? sweep_addr : in_addr;

  // Memories.
  logic          u_we, v_we, s_we, s_wdata;
  logic [IW-1:0] vel_waddr, s_waddr, face_addr;
  logic [VW-1:0] vel_wdata, u_rdata, v_rdata;
  logic          s_rdata;
  logic signed [VW-1:0] relaxed;
  logic          write_face;
  logic          skip_q;

  assign face_addr  = sgvd_pkg::cell_idx(scol_q, srow_q);
  assign write_face = sweep_q && (step_q == 4'd9);
  assign u_we = (accept && in_ok && (opcode_i == sgvd_pkg::OP_WR_U)) ||
                (write_face && !phase_q && !skip_q);
  assign v_we = (accept && in_ok && (opcode_i == sgvd_pkg::OP_WR_V)) ||
                (write_face && phase_q && !skip_q);
  assign vel_waddr = sweep_q ? face_addr : in_addr;
  assign vel_wdata = sweep_q ? relaxed : velocity_in_i;
  assign s_we      = clr_busy_q || (accept && in_ok && (opcode_i == sgvd_pkg::OP_WR_S));
  assign s_waddr   = clr_busy_q ? clr_idx_q : in_addr;
  assign s_wdata   = clr_busy_q ? 1'b0 : solid_in_i;

  sgvd_ram #(.Width(VW), .Depth(sgvd_pkg::CELLS)) u_mem (
    .clk_i, .we_i(u_we), .waddr_i(vel_waddr), .wdata_i(vel_wdata),
    .raddr_i(rd_addr), .rdata_o(u_rdata)
  );
  sgvd_ram #(.Width(VW), .Depth(sgvd_pkg::CELLS)) v_mem (
    .clk_i, .we_i(v_we), .waddr_i(vel_waddr), .wdata_i(vel_wdata),
    .raddr_i(rd_addr), .rdata_o(v_rdata)
  );
  sgvd_ram #(.Width(1), .Depth(sgvd_pkg::CELLS)) s_mem (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(rd_addr), .rdata_o(s_rdata)
  );

  // Gathered neighbourhood of the current face.
  logic signed [VW-1:0] cen_q, far_q, am_q, ap_q, al_q;
  logic       s1_q, s2_q, s3_q, s4_q, s5_q;
  logic [VW-1:0] vel_rd;
  assign vel_rd = phase_q ? v_rdata : u_rdata;

  always_ff @(posedge clk_i) begin
    case (step_q)
      4'd1: begin
        cen_q  <= vel_rd;
        skip_q <= s_rdata;
      end
      4'd2: begin
        far_q <= vel_rd;
        s1_q  <= s_rdata;
      end
      4'd3: begin
        am_q <= vel_rd;
        s2_q <= s_rdata;
      end
      4'd4: s3_q <= s_rdata;
      4'd5: begin
        ap_q <= vel_rd;
        s4_q <= s_rdata;
      end
      4'd6: s5_q <= s_rdata;
      4'd7: begin
        al_q   <= vel_rd;
        skip_q <= skip_q | s1_q;
      end
      default: ;
    endcase
  end

  // Boundary handling, then the two Laplacian terms times their coefficients.
  logic [DW-1:0] a_idx, a_lim, q_idx, q_lim;
  logic signed [VW-1:0] al_v, far_v, am_v, ap_v;
  logic signed [SW-1:0] sum_a, sum_c;
  logic [sgvd_pkg::COEF_W-1:0] k_a, k_c;
  logic signed [PW-1:0] prod_a_q, prod_c_q;

  always_comb begin
    a_idx = phase_q ? srow_q : scol_q;
    a_lim = phase_q ? ny : nx;
    q_idx = phase_q ? scol_q : srow_q;
    q_lim = phase_q ? nx : ny;
    k_a   = phase_q ? coeff_y_q : coeff_x_q;
    k_c   = phase_q ? coeff_x_q : coeff_y_q;
    al_v  = (a_idx > One) ? al_q : '0;
    far_v = (a_idx < a_lim - One) ? far_q : cen_q;
    if ((q_idx > One) && !s2_q && !s3_q) begin
      am_v = am_q;
    end else begin
      am_v = (q_idx == One) ? cen_q : '0;
    end
    if ((q_idx < q_lim) && !s4_q && !s5_q) begin
      ap_v = ap_q;
    end else begin
      ap_v = (q_idx == q_lim) ? cen_q : '0;
    end
    sum_a = SW'(al_v) + SW'(far_v) - (SW'(cen_q) <<< 1);
    sum_c = SW'(am_v) + SW'(ap_v) - (SW'(cen_q) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (step_q == 4'd8) begin
      prod_a_q <= PW'(sum_a) * PW'($signed({1'b0, k_a}));
      prod_c_q <= PW'(sum_c) * PW'($signed({1'b0, k_c}));
    end
  end

  // Round the Q.32 sum to Q16.16 (half up), add to the centre and saturate.
  logic signed [PW:0]   acc;
  logic signed [PW-16:0] delta;
  logic signed [PW-15:0] total;
  always_comb begin
    acc   = (PW+1)'(prod_a_q) + (PW+1)'(prod_c_q) + (PW+1)'(32768);
    delta = acc[PW:16];
    total = (PW-14)'(cen_q) + (PW-14)'(delta);
    if (total > (PW-14)'(signed'(32'sh7FFF_FFFF))) begin
      relaxed = 32'sh7FFF_FFFF;
    end else if (total < (PW-14)'(signed'(-32'sh8000_0000))) begin
      relaxed = -32'sh8000_0000;
    end else begin
      relaxed = total[VW-1:0];
    end
  end

  // Sweep sequencer, clearing pass, read tracking and the output register.
  logic [DW-1:0] col_lim, row_lim;
  logic          last_row, last_col, sweep_end;
  assign col_lim   = phase_q ? nx : nx - One;
  assign row_lim   = phase_q ? ny - One : ny;
  assign last_row  = (srow_q == row_lim);
  assign last_col  = (scol_q == col_lim);
  assign sweep_end = write_face && last_row && last_col && phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      sweep_q     <= 1'b0;
      phase_q     <= 1'b0;
      scol_q      <= One;
      srow_q      <= One;
      step_q      <= '0;
      rd_pend_q   <= 1'b0;
      rd_ok_q     <= 1'b0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      out_vel_q   <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + IW'(1);
        if (clr_idx_q == LastIdx) begin
          clr_busy_q <= 1'b0;
        end
      end

      rd_pend_q <= accept && ((opcode_i == sgvd_pkg::OP_RD_U) ||
                              (opcode_i == sgvd_pkg::OP_RD_V));
      if (accept) begin
        rd_ok_q <= in_ok;
        rd_v_q  <= (opcode_i == sgvd_pkg::OP_RD_V);
      end

      if (accept && (opcode_i == sgvd_pkg::OP_SWEEP)) begin
        sweep_q <= 1'b1;
        phase_q <= 1'b0;
        scol_q  <= One;
        srow_q  <= One;
        step_q  <= '0;
      end else if (sweep_q) begin
        if (step_q == 4'd9) begin
          step_q <= '0;
          if (!last_row) begin
            srow_q <= srow_q + One;
          end else begin
            srow_q <= One;
            if (!last_col) begin
              scol_q <= scol_q + One;
            end else begin
              scol_q <= One;
              if (phase_q) begin
                sweep_q <= 1'b0;
              end else begin
                phase_q <= 1'b1;
              end
            end
          end
        end else begin
          step_q <= step_q + 4'd1;
        end
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
        done_q      <= 1'b0;
        out_vel_q   <= rd_ok_q ? (rd_v_q ? v_rdata : u_rdata) : '0;
      end else if (sweep_end) begin
        out_valid_q <= 1'b1;
        done_q      <= 1'b1;
        out_vel_q   <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign velocity_out_o = out_vel_q;
  assign sweep_done_o   = done_q;

endmodule
